// File: hw/rtl/r2fft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants and a 25-bit saturation function for the radix-2 FFT block.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int unsigned InW    = 18;
  localparam int unsigned SmpW   = 25;
  localparam int unsigned LgW    = 3;
  localparam logic [LgW-1:0] LgReset = 3'd6;

  localparam logic [0:0] CfgLog2Points = 1'b0;
  localparam logic [0:0] CfgInverse    = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSwap,
    StBfRead,
    StBfCalc,
    StBfWrite,
    StEmitRead,
    StEmitOut
  } state_e;

  typedef struct packed {
    logic swap_step;
    logic bf_read;
    logic bf_calc;
    logic bf_write;
    logic emit_read;
    logic emit_load;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic swap_done;
    logic bf_done;
    logic emit_done;
    logic out_busy;
  } stat_t;

  function automatic logic [SmpW-1:0] sat25(input logic signed [SmpW+2:0] x);
    logic signed [SmpW+2:0] hi;
    logic signed [SmpW+2:0] lo;
    hi = (SmpW+3)'(signed'({1'b0, {(SmpW-1){1'b1}}}));
    lo = -hi - (SmpW+3)'(1);
    if (x > hi) begin
      sat25 = hi[SmpW-1:0];
    end else if (x < lo) begin
      sat25 = lo[SmpW-1:0];
    end else begin
      sat25 = x[SmpW-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/r2fft_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Sequencer for reorder, butterfly stages and result emission.
// ----------------------------------------------------------------------------
module r2fft_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  r2fft_pkg::stat_t stat_i,
  output r2fft_pkg::cmd_t  cmd_o,
  output logic             idle_o
);
  import r2fft_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:     if (go_i) state_d = StSwap;
      StSwap:     if (stat_i.swap_done) state_d = StBfRead;
      StBfRead:   state_d = StBfCalc;
      StBfCalc:   state_d = StBfWrite;
      StBfWrite:  state_d = stat_i.bf_done ? StEmitRead : StBfRead;
      StEmitRead: if (!stat_i.out_busy) state_d = StEmitOut;
      StEmitOut:  state_d = stat_i.emit_done ? StIdle : StEmitRead;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.start = (state_q == StIdle) && go_i;
    unique case (state_q)
      StSwap:     cmd_o.swap_step = 1'b1;
      StBfRead:   cmd_o.bf_read = 1'b1;
      StBfCalc:   cmd_o.bf_calc = 1'b1;
      StBfWrite:  cmd_o.bf_write = 1'b1;
      StEmitRead: cmd_o.emit_read = !stat_i.out_busy;
      StEmitOut:  cmd_o.emit_load = 1'b1;
      default:    cmd_o.start = (state_q == StIdle) && go_i;
    endcase
  end

  assign idle_o = (state_q == StIdle);

  a_emit_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmitOut && stat_i.emit_done) |=> state_q == StIdle)
    else $error("emit did not return to idle");
  a_go_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && go_i) |=> state_q == StSwap)
    else $error("start lost");
  a_bf_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StBfRead |=> state_q == StBfCalc)
    else $error("butterfly sequence broken");

endmodule

// File: hw/rtl/r2fft_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_dp
// Sample and twiddle memories, butterfly unit, scaler and output register.
// ----------------------------------------------------------------------------
module r2fft_dp #(
  parameter int unsigned MaxPoints = 64,
  parameter int unsigned FracBits  = 16,
  localparam int unsigned AW = $clog2(MaxPoints),
  localparam int unsigned MaxLg = AW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic                        mode_i,
  input  logic [r2fft_pkg::InW-1:0]   re_i,
  input  logic [r2fft_pkg::InW-1:0]   im_i,
  input  logic [r2fft_pkg::LgW-1:0]   lg_cfg_i,
  input  logic                        inv_i,
  input  r2fft_pkg::cmd_t             cmd_i,
  output r2fft_pkg::stat_t            stat_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [r2fft_pkg::SmpW-1:0]  out_re_o,
  output logic [r2fft_pkg::SmpW-1:0]  out_im_o,
  output logic [5:0]                  out_index_o,
  output logic                        out_last_o
);
  import r2fft_pkg::*;

  localparam int unsigned PW = 2 * SmpW + InW + 2;

  logic [2*SmpW-1:0] smem [MaxPoints];
  logic [2*InW-1:0]  tmem [MaxPoints-1];

  logic [AW:0]   scnt_q;
  logic [AW-1:0] tcnt_q;
  logic [LgW-1:0] lg_eff;
  logic [AW:0]   npts;
  logic [AW:0]   i_q;
  logic [AW:0]   g_q;
  logic [AW:0]   base_q;
  logic [AW:0]   j_q;
  logic [1:0]    sw_ph_q;
  logic [2*InW-1:0]  w_q;
  logic signed [PW-1:0] vr_q, vi_q;
  logic [AW-1:0] rev;
  logic [AW-1:0] xa, ya;
  logic [2*SmpW-1:0] rd_q;

  always_comb begin
    logic [LgW-1:0] l;
    l = lg_cfg_i;
    if (l == '0) l = LgW'(1);
    if (32'(l) > MaxLg) l = LgW'(MaxLg);
    lg_eff = l;
  end
  assign npts = (AW+1)'(1) << lg_eff;

  always_comb begin
    rev = '0;
    for (int b = 0; b < AW; b++) begin
      if (b < 32'(lg_eff)) rev[32'(lg_eff) - 1 - b] = i_q[b];
    end
  end

  assign xa = AW'(base_q + j_q);
  assign ya = AW'(base_q + j_q + g_q);

  // loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
      tcnt_q <= '0;
    end else if (cmd_i.start) begin
      scnt_q <= '0;
      tcnt_q <= '0;
    end else if (load_i) begin
      if (mode_i) begin
        if (32'(tcnt_q) < MaxPoints - 1) tcnt_q <= tcnt_q + AW'(1);
      end else if (scnt_q < (AW+1)'(MaxPoints)) begin
        scnt_q <= scnt_q + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && mode_i && 32'(tcnt_q) < MaxPoints - 1) begin
      tmem[tcnt_q] <= {im_i, re_i};
    end
  end

  // sequencing counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0; g_q <= '0; base_q <= '0; j_q <= '0; sw_ph_q <= '0;
    end else if (cmd_i.start) begin
      i_q <= '0; g_q <= (AW+1)'(1); base_q <= '0; j_q <= '0; sw_ph_q <= '0;
    end else if (cmd_i.swap_step) begin
      if (sw_ph_q == 2'd2 || (sw_ph_q == 2'd0 && (AW+1)'(rev) <= i_q)) begin
        sw_ph_q <= '0;
        i_q <= (i_q + (AW+1)'(1) == npts) ? '0 : i_q + (AW+1)'(1);
      end else begin
        sw_ph_q <= sw_ph_q + 2'd1;
      end
    end else if (cmd_i.bf_write) begin
      if (j_q + (AW+1)'(1) < g_q) begin
        j_q <= j_q + (AW+1)'(1);
      end else begin
        j_q <= '0;
        if (base_q + (g_q << 1) < npts) begin
          base_q <= base_q + (g_q << 1);
        end else begin
          base_q <= '0;
          g_q <= g_q << 1;
        end
      end
    end else if (cmd_i.emit_load) begin
      i_q <= i_q + (AW+1)'(1);
    end
  end

  // sample memory: one read address, up to two write addresses
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [2*SmpW-1:0] wd;
  logic          re_en;

  always_comb begin
    we = 1'b0; wa = '0; wd = '0; ra = '0; re_en = 1'b0;
    priority if (load_i && !mode_i && scnt_q < (AW+1)'(MaxPoints) && !cmd_i.swap_step
                 && !cmd_i.bf_write) begin
      we = 1'b1; wa = AW'(scnt_q);
      wd = {{(SmpW-InW){im_i[InW-1]}}, im_i, {(SmpW-InW){re_i[InW-1]}}, re_i};
    end else if (cmd_i.swap_step) begin
      re_en = 1'b1;
      ra = (sw_ph_q == 2'd0) ? AW'(i_q) : rev;
      if (sw_ph_q == 2'd1) begin
        we = 1'b1; wa = rev; wd = rd_q;
      end else if (sw_ph_q == 2'd2) begin
        we = 1'b1; wa = AW'(i_q); wd = rd_q;
      end
    end else if (cmd_i.bf_write) begin
      we = 1'b1; wa = xa;
    end else begin
      re_en = cmd_i.bf_read || cmd_i.bf_calc || cmd_i.emit_read;
      ra = cmd_i.bf_read ? ya : (cmd_i.bf_calc ? xa : AW'(i_q));
    end
  end

  // butterfly: rd_q holds Y during calc and X during write
  logic signed [SmpW-1:0] dr, di;
  logic signed [InW-1:0]  wr, wi;
  logic signed [SmpW+InW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic [2*SmpW-1:0] xo, yo;
  logic signed [PW-1:0] half;
  logic signed [PW-1:0] vrs, vis;
  assign half = PW'(1) <<< (FracBits - 1);
  assign dr = rd_q[SmpW-1:0];
  assign di = rd_q[2*SmpW-1:SmpW];
  assign wr = w_q[InW-1:0];
  assign wi = w_q[2*InW-1:InW];
  assign p_rr = dr * wr;
  assign p_ii = di * wi;
  assign p_ri = dr * wi;
  assign p_ir = di * wr;
  assign vrs = (vr_q + half) >>> FracBits;
  assign vis = (vi_q + half) >>> FracBits;
  assign xo = {sat25((SmpW+3)'(di) + (SmpW+3)'(vis)), sat25((SmpW+3)'(dr) + (SmpW+3)'(vrs))};
  assign yo = {sat25((SmpW+3)'(di) - (SmpW+3)'(vis)), sat25((SmpW+3)'(dr) - (SmpW+3)'(vrs))};

  always_ff @(posedge clk_i) begin
    if (we) smem[wa] <= cmd_i.bf_write ? xo : wd;
    if (cmd_i.bf_write) smem[ya] <= yo;
    if (re_en) rd_q <= smem[ra];
    if (cmd_i.bf_read) w_q <= tmem[AW'(g_q - (AW+1)'(1) + j_q)];
    if (cmd_i.bf_calc) begin
      vr_q <= PW'(p_rr) - PW'(p_ii);
      vi_q <= PW'(p_ri) + PW'(p_ir);
    end
  end

  assign stat_o.swap_done = cmd_i.swap_step && (sw_ph_q == 2'd2 ||
      (sw_ph_q == 2'd0 && (AW+1)'(rev) <= i_q)) && (i_q + (AW+1)'(1) == npts);
  assign stat_o.bf_done = (j_q + (AW+1)'(1) >= g_q) && (base_q + (g_q << 1) >= npts)
      && ((g_q << 1) >= npts);
  assign stat_o.emit_done = (i_q + (AW+1)'(1) == npts);

  // output register
  logic signed [SmpW:0] sr, si, h;
  assign h = (SmpW+1)'(1) <<< (lg_eff - LgW'(1));
  assign sr = inv_i ? (($signed({rd_q[SmpW-1], rd_q[SmpW-1:0]}) + h) >>> lg_eff)
                    : $signed({rd_q[SmpW-1], rd_q[SmpW-1:0]});
  assign si = inv_i ? (($signed({rd_q[2*SmpW-1], rd_q[2*SmpW-1:SmpW]}) + h) >>> lg_eff)
                    : $signed({rd_q[2*SmpW-1], rd_q[2*SmpW-1:SmpW]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_re_o    <= sr[SmpW-1:0];
      out_im_o    <= si[SmpW-1:0];
      out_index_o <= 6'(i_q);
      out_last_o  <= (i_q + (AW+1)'(1) == npts);
    end
  end

  assign stat_o.out_busy  = out_valid_o && !out_ready_i;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd_i.emit_load)
    else $error("result overwritten");
  a_scnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q <= (AW+1)'(MaxPoints))
    else $error("sample count overflow");
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> scnt_q == '0)
    else $error("count not cleared");

endmodule

// File: hw/rtl/radix2_complex_fft.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_complex_fft
// In-place radix-2 DIT FFT over loaded samples with a loaded twiddle table.
// ----------------------------------------------------------------------------
// The block takes one load word per cycle while idle. A sample word marked last
// starts a transform of n points: a bit-reversed reorder that swaps each
// reversed pair, then (n/2)*log2(n) butterflies, each as read Y, read X,
// write both, then n results, each read and loaded into the output register,
// held back while the output stalls. The block takes no word during a transform.
module radix2_complex_fft #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned TWIDDLE_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value_re[17:0], value_im[35:18], zero fill
  input  logic        s_axis_tuser,  // mode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // out_re[24:0], out_im[49:25], out_index[55:50]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i
);
  import r2fft_pkg::*;

  logic [LgW-1:0] lg_q;
  logic           inv_q;
  logic           idle, load, go;
  cmd_t           cmd;
  stat_t          stat;
  logic [SmpW-1:0] ore, oim;
  logic [5:0]     oidx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q  <= LgReset;
      inv_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLog2Points: lg_q <= cfg_data_i;
        CfgInverse:    inv_q <= cfg_data_i[0];
        default:       lg_q <= lg_q;
      endcase
    end
  end

  assign s_axis_tready = idle;
  assign load = s_axis_tvalid && s_axis_tready;
  assign go   = load && !s_axis_tuser && s_axis_tlast;

  r2fft_ctrl u_ctrl (
    .clk_i, .rst_ni, .go_i(go), .stat_i(stat), .cmd_o(cmd), .idle_o(idle)
  );

  r2fft_dp #(.MaxPoints(MAX_POINTS), .FracBits(TWIDDLE_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni,
    .load_i(load), .mode_i(s_axis_tuser),
    .re_i(s_axis_tdata[17:0]), .im_i(s_axis_tdata[35:18]),
    .lg_cfg_i(lg_q), .inv_i(inv_q),
    .cmd_i(cmd), .stat_o(stat),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .out_re_o(ore), .out_im_o(oim), .out_index_o(oidx), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {oidx, oim, ore};

endmodule
